### hw/rtl/rti_pkg.sv
// Shared types, constants and helpers for the ray/triangle intersection pipeline.
// No dependencies; imported by every rti_* module and by the top level.
package rti_pkg;

   // Quotient bits of the distance divider, one per stage
   localparam int QuoW = 31;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_ORIGIN_Z  = 3'd2,
      CSR_DIR_X     = 3'd3,
      CSR_DIR_Y     = 3'd4,
      CSR_DIR_Z     = 3'd5,
      CSR_COS_THR   = 3'd6,
      CSR_T_MIN     = 3'd7
   } csr_addr_type;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [15:0] dir_type;
   typedef logic signed [49:0] wcomp_type;
   typedef logic signed [33:0] pos_type;

   typedef struct packed {
      coord_type [2:0] origin;
      dir_type   [2:0] dir;
      logic      [28:0] cos_thr;
      logic      [30:0] t_min;
   } rti_cfg_type;

   // vertex [A,B,C][x,y,z]; w = normal cross edge vector, one per edge
   typedef struct packed {
      coord_type [2:0][2:0] vert;
      wcomp_type [2:0][2:0] w;
      logic                 miss;
      logic                 neg;
   } rti_carry_type;

   typedef struct packed {
      rti_carry_type carry;
      logic [31:0]   divisor;
      logic [31:0]   rem;
      logic [QuoW-1:0] quo;
      logic [QuoW-1:0] dlo;
      logic          sat;
      logic          nz;
   } rti_div_type;

   typedef struct packed {
      logic            hit;
      logic [30:0]     dist_t;
      coord_type [2:0] point;
   } rti_result_type;

   function automatic int next3(int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

   function automatic coord_type sat32(pos_type v);
      coord_type r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/rti_front.sv
// Front stages: plane dot products, normal-cross-edge vectors, divider operands.
// Depends on rti_pkg.
module rti_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_vld,
   input  rti_pkg::coord_type [2:0][2:0]  in_vert,
   input  rti_pkg::dir_type   [2:0]       in_norm,
   input  rti_pkg::rti_cfg_type           cfg,
   output logic                           out_vld,
   output rti_pkg::rti_div_type           out_div
);
   import rti_pkg::*;

   logic [5:0] vld_ff;

   coord_type [2:0][2:0] vert0_ff, vert1_ff, vert2_ff;
   dir_type   [2:0]      norm0_ff, norm1_ff;

   logic signed [31:0] dn1_in [3];
   logic signed [31:0] dn1_ff [3];
   logic signed [32:0] d1_in [3];
   logic signed [32:0] d1_ff [3];
   logic signed [32:0] u1_in [3][3];
   logic signed [32:0] u1_ff [3][3];

   logic signed [33:0] cost2_in, cost2_ff;
   logic signed [48:0] nd2_in [3];
   logic signed [48:0] nd2_ff [3];
   logic signed [48:0] wp2_in [3][3][2];
   logic signed [48:0] wp2_ff [3][3][2];

   logic signed [50:0] num3_in, num3_ff;
   logic [31:0]        ucost3_in, ucost3_ff, ucost4_ff;
   logic               cneg3_ff;
   rti_carry_type      carry3_in, carry3_ff, carry4_in, carry4_ff;

   logic [49:0]        unum4_in, unum4_ff;
   logic [63:0]        dvd5;
   rti_div_type        div5_in, div5_ff;

   // direction dot normal, origin offset, edge vectors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dn1_in[i] = $signed(norm0_ff[i]) * $signed(cfg.dir[i]);
         d1_in[i]  = 33'($signed(vert0_ff[0][i])) - 33'($signed(cfg.origin[i]));
         for (int e = 0; e < 3; e++) begin
            u1_in[e][i] = 33'($signed(vert0_ff[next3(e)][i])) - 33'($signed(vert0_ff[e][i]));
         end
      end
   end

   always_comb begin
      cost2_in = 34'(dn1_ff[0]) + 34'(dn1_ff[1]) + 34'(dn1_ff[2]);
      for (int i = 0; i < 3; i++) begin
         nd2_in[i] = d1_ff[i] * $signed(norm1_ff[i]);
         for (int e = 0; e < 3; e++) begin
            wp2_in[e][i][0] = $signed(norm1_ff[next3(i)]) * u1_ff[e][next3(next3(i))];
            wp2_in[e][i][1] = $signed(norm1_ff[next3(next3(i))]) * u1_ff[e][next3(i)];
         end
      end
   end

   always_comb begin
      num3_in   = 51'(nd2_ff[0]) + 51'(nd2_ff[1]) + 51'(nd2_ff[2]);
      ucost3_in = cost2_ff[33] ? 32'(-cost2_ff) : 32'(cost2_ff);
      carry3_in.vert = vert2_ff;
      for (int e = 0; e < 3; e++) begin
         for (int i = 0; i < 3; i++) begin
            carry3_in.w[e][i] = 50'(wp2_ff[e][i][0]) - 50'(wp2_ff[e][i][1]);
         end
      end
      // near-parallel ray: drop
      carry3_in.miss = (ucost3_in <= 32'(cfg.cos_thr));
      carry3_in.neg  = 1'b0;
   end

   always_comb begin
      unum4_in      = num3_ff[50] ? 50'(-num3_ff) : 50'(num3_ff);
      carry4_in     = carry3_ff;
      carry4_in.neg = num3_ff[50] ^ cneg3_ff;
   end

   always_comb begin
      dvd5            = {unum4_ff, 14'd0};
      div5_in.carry   = carry4_ff;
      div5_in.divisor = ucost4_ff;
      div5_in.sat     = (dvd5 >= {1'b0, ucost4_ff, 31'd0});
      div5_in.nz      = (dvd5 >= 64'(ucost4_ff));
      div5_in.rem     = dvd5[62:31];
      div5_in.quo     = '0;
      div5_in.dlo     = dvd5[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vert0_ff  <= in_vert;
         norm0_ff  <= in_norm;
         dn1_ff    <= dn1_in;
         d1_ff     <= d1_in;
         u1_ff     <= u1_in;
         vert1_ff  <= vert0_ff;
         norm1_ff  <= norm0_ff;
         cost2_ff  <= cost2_in;
         nd2_ff    <= nd2_in;
         wp2_ff    <= wp2_in;
         vert2_ff  <= vert1_ff;
         num3_ff   <= num3_in;
         ucost3_ff <= ucost3_in;
         cneg3_ff  <= cost2_ff[33];
         carry3_ff <= carry3_in;
         unum4_ff  <= unum4_in;
         ucost4_ff <= ucost3_ff;
         carry4_ff <= carry4_in;
         div5_ff   <= div5_in;
      end
   end

   assign out_vld = vld_ff[5];
   assign out_div = div5_ff;

endmodule

### hw/rtl/rti_div.sv
// Pipelined restoring divider for the plane distance, one quotient bit per stage.
// Depends on rti_pkg.
module rti_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  rti_pkg::rti_div_type  in_div,
   output logic                  out_vld,
   output rti_pkg::rti_div_type  out_div
);
   import rti_pkg::*;

   logic [QuoW-1:0] vld_ff;
   rti_div_type     st_in [QuoW];
   rti_div_type     st_ff [QuoW];

   for (genvar g = 0; g < QuoW; g++) begin : g_step
      rti_div_type cur;
      logic [32:0] trial;

      if (g == 0) begin : g_first
         assign cur = in_div;
      end else begin : g_next
         assign cur = st_ff[g-1];
      end

      always_comb begin
         trial     = {cur.rem, cur.dlo[QuoW-1]};
         st_in[g]  = cur;
         st_in[g].dlo = {cur.dlo[QuoW-2:0], 1'b0};
         if (trial >= {1'b0, cur.divisor}) begin
            st_in[g].rem = 32'(trial - {1'b0, cur.divisor});
            st_in[g].quo = {cur.quo[QuoW-2:0], 1'b1};
         end else begin
            st_in[g].rem = trial[31:0];
            st_in[g].quo = {cur.quo[QuoW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QuoW-2:0], in_vld};
      end
   end

   assign out_vld = vld_ff[QuoW-1];
   assign out_div = st_ff[QuoW-1];

endmodule

### hw/rtl/rti_edge.sv
// Back stages: distance limits, hit point, edge sign tests, result forming.
// Depends on rti_pkg.
module rti_edge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_vld,
   input  rti_pkg::rti_div_type    in_div,
   input  rti_pkg::rti_cfg_type    cfg,
   output logic                    out_vld,
   output rti_pkg::rti_result_type out_res
);
   import rti_pkg::*;

   logic [6:0] vld_ff;

   logic [30:0]        t0_in, t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic               miss0_in, miss0_ff, miss1_ff, miss2_ff, miss3_ff;
   logic               miss4_ff, miss5_ff, miss6_ff;
   rti_carry_type      carry0_ff, carry1_ff, carry2_ff;
   wcomp_type [2:0][2:0] w3_ff;

   logic signed [46:0] dt1_in [3];
   logic signed [46:0] dt1_ff [3];
   pos_type            p2_in [3];
   pos_type            p2_ff [3];
   pos_type            p3_ff [3];
   pos_type            p4_ff [3];
   pos_type            p5_ff [3];
   pos_type            p6_ff [3];
   logic signed [34:0] v3_in [3][3];
   logic signed [34:0] v3_ff [3][3];
   logic signed [60:0] pl4_in [3][3];
   logic signed [60:0] pl4_ff [3][3];
   logic signed [59:0] ph4_in [3][3];
   logic signed [59:0] ph4_ff [3][3];
   logic signed [85:0] sc5_in [3][3];
   logic signed [85:0] sc5_ff [3][3];
   logic signed [87:0] s6_in [3];
   logic signed [87:0] s6_ff [3];
   logic [2:0]         neg6, pos6;
   logic               hit6;

   always_comb begin
      t0_in    = in_div.sat ? '1 : in_div.quo;
      // near-parallel, behind the origin, or nearer than the minimum distance
      miss0_in = in_div.carry.miss | (in_div.carry.neg & in_div.nz) | (t0_in < cfg.t_min);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dt1_in[i] = $signed(cfg.dir[i]) * $signed({1'b0, t0_ff});
         p2_in[i]  = 34'($signed(cfg.origin[i])) + 34'(dt1_ff[i] >>> 14);
         for (int e = 0; e < 3; e++) begin
            v3_in[e][i]  = 35'(p2_ff[i]) - 35'($signed(carry2_ff.vert[e][i]));
            pl4_in[e][i] = v3_ff[e][i] * $signed({1'b0, w3_ff[e][i][24:0]});
            ph4_in[e][i] = v3_ff[e][i] * $signed(w3_ff[e][i][49:25]);
            sc5_in[e][i] = (86'(ph4_ff[e][i]) <<< 25) + 86'(pl4_ff[e][i]);
         end
      end
      for (int e = 0; e < 3; e++) begin
         s6_in[e] = 88'(sc5_ff[e][0]) + 88'(sc5_ff[e][1]) + 88'(sc5_ff[e][2]);
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         neg6[e] = s6_ff[e][87];
         pos6[e] = !s6_ff[e][87] && (s6_ff[e] != '0);
      end
      hit6 = !miss6_ff && ((neg6 == 3'b000) || (pos6 == 3'b000));
      out_res.hit    = hit6;
      out_res.dist_t = hit6 ? t6_ff : '0;
      for (int i = 0; i < 3; i++) begin
         out_res.point[i] = hit6 ? sat32(p6_ff[i]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff     <= t0_in;
         miss0_ff  <= miss0_in;
         carry0_ff <= in_div.carry;
         dt1_ff    <= dt1_in;
         t1_ff     <= t0_ff;
         miss1_ff  <= miss0_ff;
         carry1_ff <= carry0_ff;
         p2_ff     <= p2_in;
         t2_ff     <= t1_ff;
         miss2_ff  <= miss1_ff;
         carry2_ff <= carry1_ff;
         v3_ff     <= v3_in;
         w3_ff     <= carry2_ff.w;
         p3_ff     <= p2_ff;
         t3_ff     <= t2_ff;
         miss3_ff  <= miss2_ff;
         pl4_ff    <= pl4_in;
         ph4_ff    <= ph4_in;
         p4_ff     <= p3_ff;
         t4_ff     <= t3_ff;
         miss4_ff  <= miss3_ff;
         sc5_ff    <= sc5_in;
         p5_ff     <= p4_ff;
         t5_ff     <= t4_ff;
         miss5_ff  <= miss4_ff;
         s6_ff     <= s6_in;
         p6_ff     <= p5_ff;
         t6_ff     <= t5_ff;
         miss6_ff  <= miss5_ff;
      end
   end

   assign out_vld = vld_ff[6];

endmodule

### hw/rtl/ray_triangle_intersect.sv
// Ray/triangle intersection engine: top level with register port and output skid.
// Depends on rti_pkg, rti_front, rti_div and rti_edge.
//
// Usage:
//   Program the ray (origin, direction), the parallel limit and the minimum
//   distance over the csr_ port while no triangle is in flight. pready is tied
//   high, so each write takes the usual setup and access cycles.
//   Each req_ beat carries one triangle (three vertices, face normal). Each
//   triangle yields exactly one rsp_ beat, in order: hit, distance and hit
//   point, or all zeros on a miss.
//   Pipeline: 6 front stages, 31 divider stages (one quotient bit each),
//   7 back stages and the output register.
//   Throughput: one triangle per cycle while req_ready is high, set by the fully pipelined divider.
//   req_ready only drops when a result sits in the skid register, i.e. the
//   receiver stalled while another result arrived; the pipeline then holds
//   in place until the skid drains. Nothing is dropped or repeated.
//   Reset (synchronous) empties the pipeline and loads the register defaults:
//   origin zero, direction +z, parallel limit 2684, minimum distance 7.
module ray_triangle_intersect (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vert_a_x,
   input  logic signed [31:0] req_vert_a_y,
   input  logic signed [31:0] req_vert_a_z,
   input  logic signed [31:0] req_vert_b_x,
   input  logic signed [31:0] req_vert_b_y,
   input  logic signed [31:0] req_vert_b_z,
   input  logic signed [31:0] req_vert_c_x,
   input  logic signed [31:0] req_vert_c_y,
   input  logic signed [31:0] req_vert_c_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [30:0]        rsp_dist_t,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import rti_pkg::*;

   coord_type   origin_x_ff, origin_y_ff, origin_z_ff;
   dir_type     dir_x_ff, dir_y_ff, dir_z_ff;
   logic [28:0] cos_thr_ff;
   logic [30:0] t_min_ff;
   logic        csr_wr;
   rti_cfg_type cfg;

   coord_type [2:0][2:0] in_vert;
   dir_type   [2:0]      in_norm;

   logic           adv;
   logic           front_vld, div_vld, edge_vld, arrive, out_free;
   rti_div_type    front_div, div_out;
   rti_result_type edge_res;

   logic           rsp_vld_in, rsp_vld_ff, skid_vld_in, skid_vld_ff;
   rti_result_type rsp_res_in, rsp_res_ff, skid_res_in, skid_res_ff;

   // register port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         dir_x_ff    <= '0;
         dir_y_ff    <= '0;
         dir_z_ff    <= 16'sd16384;
         cos_thr_ff  <= 29'd2684;
         t_min_ff    <= 31'd7;
      end else if (csr_wr) begin
         case (csr_addr_type'(csr_paddr[4:2]))
            CSR_ORIGIN_X: origin_x_ff <= csr_pwdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_pwdata;
            CSR_ORIGIN_Z: origin_z_ff <= csr_pwdata;
            CSR_DIR_X:    dir_x_ff    <= csr_pwdata[15:0];
            CSR_DIR_Y:    dir_y_ff    <= csr_pwdata[15:0];
            CSR_DIR_Z:    dir_z_ff    <= csr_pwdata[15:0];
            CSR_COS_THR:  cos_thr_ff  <= csr_pwdata[28:0];
            CSR_T_MIN:    t_min_ff    <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_addr_type'(csr_paddr[4:2]))
         CSR_ORIGIN_X: csr_prdata = origin_x_ff;
         CSR_ORIGIN_Y: csr_prdata = origin_y_ff;
         CSR_ORIGIN_Z: csr_prdata = origin_z_ff;
         CSR_DIR_X:    csr_prdata = 32'($signed(dir_x_ff));
         CSR_DIR_Y:    csr_prdata = 32'($signed(dir_y_ff));
         CSR_DIR_Z:    csr_prdata = 32'($signed(dir_z_ff));
         CSR_COS_THR:  csr_prdata = 32'(cos_thr_ff);
         CSR_T_MIN:    csr_prdata = 32'(t_min_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.origin[0] = origin_x_ff;
      cfg.origin[1] = origin_y_ff;
      cfg.origin[2] = origin_z_ff;
      cfg.dir[0]    = dir_x_ff;
      cfg.dir[1]    = dir_y_ff;
      cfg.dir[2]    = dir_z_ff;
      cfg.cos_thr   = cos_thr_ff;
      cfg.t_min     = t_min_ff;
      in_vert[0][0] = req_vert_a_x;
      in_vert[0][1] = req_vert_a_y;
      in_vert[0][2] = req_vert_a_z;
      in_vert[1][0] = req_vert_b_x;
      in_vert[1][1] = req_vert_b_y;
      in_vert[1][2] = req_vert_b_z;
      in_vert[2][0] = req_vert_c_x;
      in_vert[2][1] = req_vert_c_y;
      in_vert[2][2] = req_vert_c_z;
      in_norm[0]    = req_normal_x;
      in_norm[1]    = req_normal_y;
      in_norm[2]    = req_normal_z;
   end

   // whole pipeline advances unless the skid holds a beat
   assign adv       = !skid_vld_ff;
   assign req_ready = adv;

   rti_front u_front (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (req_valid),
      .in_vert (in_vert),
      .in_norm (in_norm),
      .cfg     (cfg),
      .out_vld (front_vld),
      .out_div (front_div)
   );

   rti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (front_vld),
      .in_div  (front_div),
      .out_vld (div_vld),
      .out_div (div_out)
   );

   rti_edge u_edge (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (div_vld),
      .in_div  (div_out),
      .cfg     (cfg),
      .out_vld (edge_vld),
      .out_res (edge_res)
   );

   // output register with one skid entry
   assign arrive   = edge_vld & adv;
   assign out_free = !rsp_vld_ff || rsp_ready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_res_in  = rsp_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_res_in  = skid_res_ff;
            skid_vld_in = 1'b0;
         end else begin
            rsp_vld_in = arrive;
            rsp_res_in = edge_res;
         end
      end else if (arrive) begin
         skid_vld_in = 1'b1;
         skid_res_in = edge_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_hit     = rsp_res_ff.hit;
   assign rsp_dist_t  = rsp_res_ff.dist_t;
   assign rsp_point_x = rsp_res_ff.point[0];
   assign rsp_point_y = rsp_res_ff.point[1];
   assign rsp_point_z = rsp_res_ff.point[2];

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid holds a beat while the output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (edge_vld && adv && rsp_vld_ff && !rsp_ready) |=> skid_vld_ff)
      else $error("result arriving at a stalled output was not caught");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_res_ff.hit) |->
         (rsp_res_ff.dist_t == '0 && rsp_res_ff.point[0] == '0 &&
          rsp_res_ff.point[1] == '0 && rsp_res_ff.point[2] == '0))
      else $error("miss beat carries non-zero fields");

endmodule
